// ----- design/assoc_cache_fifo_replace_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the associative cache
// Shared property shapes used by the modules that carry assertions.
// ----------------------------------------------------------------------------
`ifndef ASSOC_CACHE_FIFO_REPLACE_TOP_DEFINES_SVH
`define ASSOC_CACHE_FIFO_REPLACE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define ACFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acfr: same-cycle check failed");

// Next-cycle implication, disabled while reset is applied.
`define ACFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acfr: next-cycle check failed");

`endif

// ----- design/acfr_pkg.sv -----
// ----------------------------------------------------------------------------
// acfr_pkg
// Types and constants shared by the associative cache modules.
// ----------------------------------------------------------------------------
package acfr_pkg;

    localparam int KEY_W  = 64;
    localparam int DATA_W = 64;

    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request
        logic scan;      // read the next key entry
        logic take;      // record the scan outcome
        logic finish;    // write on put, read data on get
        logic out_load;  // fill the response register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;         // the entry under compare matches
        logic issue_last;  // the scan address is the final entry
    } t_dp_stat;

endpackage

// ----- design/acfr_req_if.sv -----
// ----------------------------------------------------------------------------
// acfr_req_if
// Request channel: operation, key and write data with valid/ready.
// ----------------------------------------------------------------------------
interface acfr_req_if;
    import acfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, func, key, write_data, input ready);
    modport sink   (input valid, func, key, write_data, output ready);
endinterface

// ----- design/acfr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// acfr_rsp_if
// Response channel: hit flag and read data with valid/ready.
// ----------------------------------------------------------------------------
interface acfr_rsp_if;
    import acfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, hit, read_data, input ready);
    modport sink   (input valid, hit, read_data, output ready);
endinterface

// ----- design/acfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// acfr_ctrl
// Sequencer: accepts a request, steps the key scan, commits, responds.
// ----------------------------------------------------------------------------
module acfr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output acfr_pkg::t_dp_cmd  o_cmd,
    input  acfr_pkg::t_dp_stat i_stat
);
    import acfr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The compare trails the key read: it sees the entry read in the cycle before.
                if (i_stat.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_FINISH;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_stat.issue_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                o_cmd.take = 1'b1;
                n_state    = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_RESP;
            end
            ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- design/acfr_dp.sv -----
// ----------------------------------------------------------------------------
// acfr_dp
// Key and data memories, valid bits, replacement pointer and the compare.
// ----------------------------------------------------------------------------
`include "assoc_cache_fifo_replace_top_defines.svh"

module acfr_dp #(
    parameter int ENTRIES    = 16,
    parameter int KEY_WIDTH  = 64,
    parameter int DATA_WIDTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  acfr_pkg::t_dp_cmd           i_cmd,
    output acfr_pkg::t_dp_stat          o_stat,
    input  logic                        i_func,
    input  logic [acfr_pkg::KEY_W-1:0]  i_key,
    input  logic [acfr_pkg::DATA_W-1:0] i_write_data,
    output logic                        o_hit,
    output logic [acfr_pkg::DATA_W-1:0] o_read_data
);
    import acfr_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic [KEY_WIDTH-1:0]  r_key_mem  [ENTRIES];
    logic [DATA_WIDTH-1:0] r_data_mem [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [IW-1:0]         r_ptr;
    logic [IW-1:0]         n_ptr;

    logic                  r_func;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic [IW-1:0]         r_addr;
    logic                  r_cmp_en;
    logic                  r_rd_vld;
    logic [KEY_WIDTH-1:0]  r_rd_key;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_match;
    logic [IW-1:0]         r_match_idx;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_out_hit;
    logic [DATA_WIDTH-1:0] r_out_data;

    logic                  w_put_commit;
    logic [IW-1:0]         w_target;

    assign o_stat.hit        = r_cmp_en && r_rd_vld && (r_rd_key == r_key);
    assign o_stat.issue_last = (r_addr == IW'(ENTRIES - 1));

    assign w_put_commit = i_cmd.finish && (r_func == FUNC_PUT);
    assign w_target     = r_match ? r_match_idx : r_ptr;
    assign n_ptr        = (r_ptr == IW'(ENTRIES - 1)) ? '0 : r_ptr + 1'b1;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_key   <= i_key[KEY_WIDTH-1:0];
            r_wdata <= i_write_data[DATA_WIDTH-1:0];
        end
    end

    // Key memory: one read per scan step, written on a put.
    always_ff @(posedge i_clk) begin
        if (w_put_commit) begin
            r_key_mem[w_target] <= r_key;
        end
        if (i_cmd.scan) begin
            r_rd_key  <= r_key_mem[r_addr];
            r_cmp_idx <= r_addr;
        end
    end

    // Data memory: written on a put, read on a get.
    always_ff @(posedge i_clk) begin
        if (w_put_commit) begin
            r_data_mem[w_target] <= r_wdata;
        end
        if (i_cmd.finish && (r_func == FUNC_GET)) begin
            r_rd_data <= r_data_mem[r_match_idx];
        end
    end

    // Scan control, valid bits and the replacement pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ptr       <= '0;
            r_addr      <= '0;
            r_cmp_en    <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_match     <= 1'b0;
            r_match_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_addr   <= '0;
                r_cmp_en <= 1'b0;
            end else begin
                r_cmp_en <= i_cmd.scan;
                if (i_cmd.scan) begin
                    r_addr   <= r_addr + 1'b1;
                    r_rd_vld <= r_valid[r_addr];
                end
            end
            if (i_cmd.take) begin
                r_match     <= o_stat.hit;
                r_match_idx <= r_cmp_idx;
            end
            if (w_put_commit) begin
                r_valid[w_target] <= 1'b1;
                // The pointer moves whenever the entry it names is written.
                if (w_target == r_ptr) begin
                    r_ptr <= n_ptr;
                end
            end
        end
    end

    // Response register; a put or a miss returns zero data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_hit  <= r_match;
            r_out_data <= (r_match && (r_func == FUNC_GET)) ? r_rd_data : '0;
        end
    end

    assign o_hit       = r_out_hit;
    assign o_read_data = DATA_W'(r_out_data);

    `ACFR_ASSERT_NEXT(a_put_sets_valid, i_clk, i_rst_n, w_put_commit, r_valid[$past(w_target)])
    `ACFR_ASSERT_NEXT(a_ptr_hold, i_clk, i_rst_n, !w_put_commit, $stable(r_ptr))
    `ACFR_ASSERT_IMP(a_match_is_valid, i_clk, i_rst_n, r_match, r_valid[r_match_idx])
    `ACFR_ASSERT_NEXT(a_miss_zero_data, i_clk, i_rst_n, i_cmd.out_load, r_out_hit || (r_out_data == '0))
endmodule

// ----- design/assoc_cache_fifo_replace_top.sv -----
// A fully associative key/value store of ENTRIES entries with first-in first-out
// replacement. A put (func 0) updates the first valid entry holding the key or
// else writes the entry at the replacement pointer; its response has hit set when
// an existing entry was updated and read_data zero. A get (func 1) returns hit
// and the stored data of the first matching valid entry, or zero on a miss. One
// request is handled at a time: the keys sit in a single-port memory that is
// scanned one entry per cycle, and the next request is accepted in the cycle after
// the response is taken. Valid bits and the pointer clear on reset; no memory
// clearing pass is needed.
// ----------------------------------------------------------------------------
// assoc_cache_fifo_replace_top
// Top level: request/response channels around controller and datapath.
// ----------------------------------------------------------------------------
module assoc_cache_fifo_replace_top #(
    parameter int ENTRIES    = 16,
    parameter int KEY_WIDTH  = 64,
    parameter int DATA_WIDTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acfr_req_if.sink   i_req,
    acfr_rsp_if.source o_rsp
);
    import acfr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    acfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    acfr_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_WIDTH  (KEY_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_func       (i_req.func),
        .i_key        (i_req.key),
        .i_write_data (i_req.write_data),
        .o_hit        (o_rsp.hit),
        .o_read_data  (o_rsp.read_data)
    );
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives put and get requests into the associative cache and keeps a mirror
// of its entries and replacement pointer. Every response is checked in order
// against the mirror's prediction, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import acfr_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;
    localparam int POOL_SIZE    = 24;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_data;
    } t_cache_rsp;

    class cache_mirror;
        logic [KEY_W-1:0]  key_store  [ENTRIES];
        logic [DATA_W-1:0] data_store [ENTRIES];
        bit                valid_bits [ENTRIES];
        int unsigned       fifo_ptr;
        t_cache_rsp        owed_rsps [$];
        int unsigned       mismatches;
        int unsigned       puts;
        int unsigned       gets;
        int unsigned       get_hits;
        int unsigned       evictions;
        int unsigned       responses;

        function new();
            foreach (valid_bits[i]) valid_bits[i] = 1'b0;
            fifo_ptr   = 0;
            mismatches = 0;
            puts       = 0;
            gets       = 0;
            get_hits   = 0;
            evictions  = 0;
            responses  = 0;
        endfunction

        // Lowest valid entry holding the key, or -1.
        function int find_entry(logic [KEY_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_bits[i] && key_store[i] == key) return i;
            end
            return -1;
        endfunction

        function void note_request(logic func, logic [KEY_W-1:0] key,
                                   logic [DATA_W-1:0] wdata);
            int         slot;
            int         target;
            t_cache_rsp rsp;
            slot = find_entry(key);
            rsp  = '0;
            if (func == FUNC_GET) begin
                gets++;
                if (slot >= 0) begin
                    rsp.hit       = 1'b1;
                    rsp.read_data = data_store[slot];
                    get_hits++;
                end
            end else begin
                puts++;
                target = (slot >= 0) ? slot : int'(fifo_ptr);
                if (slot < 0 && valid_bits[target]) evictions++;
                key_store[target]  = key;
                data_store[target] = wdata;
                valid_bits[target] = 1'b1;
                // An update that lands on the pointer entry also moves the pointer.
                if (target == int'(fifo_ptr)) fifo_ptr = (fifo_ptr + 1) % ENTRIES;
                rsp.hit = (slot >= 0);
            end
            owed_rsps.push_back(rsp);
        endfunction

        function void check_response(logic hit, logic [DATA_W-1:0] read_data);
            t_cache_rsp exp_rsp;
            responses++;
            if (owed_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Response %0d with no request outstanding: hit=%0b data=%h",
                             responses, hit, read_data);
                return;
            end
            exp_rsp = owed_rsps.pop_front();
            if (hit !== exp_rsp.hit || read_data !== exp_rsp.read_data) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Response %0d: expected hit=%0b data=%h, got hit=%0b data=%h",
                             responses, exp_rsp.hit, exp_rsp.read_data, hit, read_data);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    bit               steady;
    int unsigned      stall_cycles;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    cache_mirror      mirror = new();

    acfr_req_if req_ch();
    acfr_rsp_if rsp_ch();

    assoc_cache_fifo_replace_top #(
        .ENTRIES    (ENTRIES),
        .KEY_WIDTH  (KEY_W),
        .DATA_WIDTH (DATA_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 17);
    endfunction

    // Mostly keys from a small pool so that hits, updates and evictions are
    // common; some differ from a pool key in a single bit, a few are fresh.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] key;
        int               roll;
        int               flip;
        roll = $urandom_range(99);
        key  = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (roll >= 88) begin
            key = rand64();
        end else if (roll >= 75) begin
            flip      = $urandom_range(KEY_W - 1);
            key[flip] = ~key[flip];
        end
        return key;
    endfunction

    task automatic send_request(input logic func, input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] wdata);
        while (take_break()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.key        <= key;
        req_ch.write_data <= wdata;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        mirror.note_request(func, key, wdata);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready)
                mirror.check_response(rsp_ch.hit, rsp_ch.read_data);
            rsp_ch.ready <= !take_break();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: nothing moved for %0d cycles, %0d responses owed",
                         STALL_LIMIT, mirror.owed_rsps.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned n;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_PUT;
        req_ch.key        <= '0;
        req_ch.write_data <= '0;
        foreach (key_pool[i]) key_pool[i] = rand64();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Lookups on an empty cache, then the all-zero and all-one keys.
        send_request(FUNC_GET, '0, '0);
        send_request(FUNC_GET, '1, '1);
        send_request(FUNC_PUT, '0, '1);
        send_request(FUNC_PUT, '1, '0);
        send_request(FUNC_GET, '0, '0);
        send_request(FUNC_GET, '1, rand64());
        // Update of an entry away from the pointer leaves the pointer alone.
        send_request(FUNC_PUT, '0, 64'h5555_5555_5555_5555);
        send_request(FUNC_GET, '0, '0);
        // Fill the remaining entries so the pointer wraps to the first one.
        for (n = 0; n < ENTRIES - 2; n++) send_request(FUNC_PUT, rand64(), rand64());
        // A new key now evicts the oldest entry, which held key zero.
        send_request(FUNC_PUT, 64'hAAAA_AAAA_AAAA_AAAA, '1);
        send_request(FUNC_GET, '0, '0);
        // Updating the entry under the pointer moves the pointer on.
        send_request(FUNC_PUT, '1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(FUNC_GET, '1, '0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 500) steady <= 1'b1;
            if (n == 800) steady <= 1'b0;
            if (n % 300 == 299) begin
                foreach (key_pool[i]) if ($urandom_range(1)) key_pool[i] = rand64();
            end
            send_request(1'($urandom_range(1)), pick_key(), rand64());
        end
        req_ch.valid <= 1'b0;

        while (mirror.owed_rsps.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 10) @(posedge i_clk);

        $display("Covered %0d puts and %0d gets: %0d get hits, %0d evictions.",
                 mirror.puts, mirror.gets, mirror.get_hits, mirror.evictions);
        $display("Checked %0d responses, %0d mismatches.", mirror.responses, mirror.mismatches);
        if (mirror.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
